FILE: rtl/core/postfix_expression_evaluator_core_assert.svh
// assertion macros for the postfix evaluator core
// expects clk and rst_n in the scope of the module that includes this file
`ifndef POSTFIX_EXPRESSION_EVALUATOR_CORE_ASSERT_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_CORE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define PFX_ASSERT_HOLDS(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("postfix evaluator check failed");

// consequent must hold in the cycle after the antecedent
`define PFX_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("postfix evaluator check failed");

`endif

FILE: rtl/core/pfx_eval_pkg.sv
// shared constants, codes and types of the postfix evaluator core
// no dependencies
`default_nettype none

package pfx_eval_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int FRAC_BITS   = 16;

    localparam int VAL_W  = 48;
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int DIV_W  = VAL_W + FRAC_BITS;
    localparam int MAG_W  = 2 * VAL_W;
    localparam int ITER_W = $clog2(DIV_W);
    localparam int ADD_W  = VAL_W + 2;
    localparam int MUL_STEPS = VAL_W;
    localparam int DIV_STEPS = DIV_W;

    localparam logic [1:0] KIND_OPERAND  = 2'd0;
    localparam logic [1:0] KIND_OPERATOR = 2'd1;
    localparam logic [1:0] KIND_END      = 2'd2;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ILLEGAL  = 2'd1,
        ST_DIV_ZERO = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_Y,
        S_RD_X,
        S_LD_X,
        S_ALU_WAIT,
        S_END_RD,
        S_END_OUT
    } ctl_state_t;

    typedef enum logic [2:0] {
        A_IDLE,
        A_ADD,
        A_MUL,
        A_DIV,
        A_SIGN,
        A_DONE
    } alu_state_t;

    typedef struct packed {
        logic start;
        op_t  op;
    } alu_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/core/pfx_eval_stack.sv
// value stack memory: one write port, one read port with registered data
// depends on pfx_eval_pkg
`default_nettype none

module pfx_eval_stack (
    input  wire logic                             clk,
    input  wire logic                             wr_en,
    input  wire logic [pfx_eval_pkg::ADDR_W-1:0]  wr_addr,
    input  wire logic [pfx_eval_pkg::VAL_W-1:0]   wr_data,
    input  wire logic                             rd_en,
    input  wire logic [pfx_eval_pkg::ADDR_W-1:0]  rd_addr,
    output logic      [pfx_eval_pkg::VAL_W-1:0]   rd_data
);
    import pfx_eval_pkg::*;

    logic [VAL_W-1:0] mem [STACK_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/pfx_eval_alu.sv
// shared arithmetic unit: saturating add and subtract, bit-serial multiply
// and restoring divide, all through one adder; depends on pfx_eval_pkg
`default_nettype none

module pfx_eval_alu (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire pfx_eval_pkg::alu_ctrl_t         ctrl,
    input  wire logic [pfx_eval_pkg::VAL_W-1:0]  x,
    input  wire logic [pfx_eval_pkg::VAL_W-1:0]  y,
    output logic                                 done,
    output logic      [pfx_eval_pkg::VAL_W-1:0]  result
);
    import pfx_eval_pkg::*;

    localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    function automatic logic [VAL_W-1:0] magnitude(input logic [VAL_W-1:0] v);
        logic [VAL_W-1:0] m;
        m = v[VAL_W-1] ? (~v + VAL_W'(1)) : v;
        return m;
    endfunction

    // sign a wide magnitude and clamp it to the value range
    function automatic logic [VAL_W-1:0] sign_sat(input logic [MAG_W-1:0] m,
                                                  input logic neg);
        logic             big;
        logic [VAL_W-1:0] r;
        big = |m[MAG_W-1:VAL_W-1];
        if (neg)
        begin
            r = big ? VAL_MIN : (~m[VAL_W-1:0] + VAL_W'(1));
        end
        else
        begin
            r = big ? VAL_MAX : m[VAL_W-1:0];
        end
        return r;
    endfunction

    alu_state_t         state_reg, state_next;
    op_t                op_reg, op_next;
    logic               neg_reg, neg_next;
    logic [ITER_W-1:0]  iter_reg, iter_next;
    logic [VAL_W-1:0]   x_reg, x_next;
    logic [VAL_W-1:0]   y_reg, y_next;
    logic [VAL_W-1:0]   a_reg, a_next;
    logic [VAL_W-1:0]   b_reg, b_next;
    logic [MAG_W-1:0]   prod_reg, prod_next;
    logic [VAL_W-1:0]   rem_reg, rem_next;
    logic [DIV_W-1:0]   dvd_reg, dvd_next;
    logic [VAL_W-1:0]   res_reg, res_next;

    logic [ADD_W-1:0]   add_a, add_b, add_sum;
    logic               add_sub;
    logic [VAL_W:0]     trial;
    logic               ge;
    logic [VAL_W-1:0]   mag_x, mag_y;

    assign mag_x = magnitude(x);
    assign mag_y = magnitude(y);
    assign trial = {rem_reg, dvd_reg[DIV_W-1]};

    // the one shared adder
    always_comb
    begin
        add_a   = '0;
        add_b   = '0;
        add_sub = 1'b0;
        unique case (state_reg)
            A_ADD:
            begin
                add_a   = {{2{x_reg[VAL_W-1]}}, x_reg};
                add_b   = {{2{y_reg[VAL_W-1]}}, y_reg};
                add_sub = (op_reg == OP_SUB);
            end
            A_MUL:
            begin
                add_a = {2'b00, prod_reg[MAG_W-1:VAL_W]};
                add_b = prod_reg[0] ? {2'b00, a_reg} : '0;
            end
            A_DIV:
            begin
                add_a   = {1'b0, trial};
                add_b   = {2'b00, b_reg};
                add_sub = 1'b1;
            end
            default:
            begin
                add_sub = 1'b0;
            end
        endcase
        add_sum = add_a + (add_sub ? ~add_b : add_b) + ADD_W'(add_sub);
    end

    // no borrow out of trial - divisor
    assign ge = ~add_sum[ADD_W-1];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            A_IDLE:
            begin
                if (ctrl.start)
                begin
                    unique case (ctrl.op)
                        OP_MUL:  state_next = A_MUL;
                        OP_DIV:  state_next = A_DIV;
                        default: state_next = A_ADD;
                    endcase
                end
            end
            A_ADD:   state_next = A_DONE;
            A_MUL:   state_next = (iter_reg == '0) ? A_SIGN : A_MUL;
            A_DIV:   state_next = (iter_reg == '0) ? A_SIGN : A_DIV;
            A_SIGN:  state_next = A_DONE;
            A_DONE:  state_next = A_IDLE;
            default: state_next = A_IDLE;
        endcase
    end

    always_comb
    begin
        op_next   = op_reg;
        neg_next  = neg_reg;
        iter_next = iter_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        prod_next = prod_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        res_next  = res_reg;
        unique case (state_reg)
            A_IDLE:
            begin
                if (ctrl.start)
                begin
                    op_next   = ctrl.op;
                    neg_next  = x[VAL_W-1] ^ y[VAL_W-1];
                    x_next    = x;
                    y_next    = y;
                    a_next    = mag_x;
                    b_next    = mag_y;
                    prod_next = {{VAL_W{1'b0}}, mag_y};
                    rem_next  = '0;
                    dvd_next  = DIV_W'(mag_x) << FRAC_BITS;
                    iter_next = (ctrl.op == OP_DIV) ? ITER_W'(DIV_STEPS - 1)
                                                    : ITER_W'(MUL_STEPS - 1);
                end
            end
            A_ADD:
            begin
                // in range when the two top bits of the true sum agree
                if (add_sum[VAL_W] == add_sum[VAL_W-1])
                begin
                    res_next = add_sum[VAL_W-1:0];
                end
                else
                begin
                    res_next = add_sum[VAL_W] ? VAL_MIN : VAL_MAX;
                end
            end
            A_MUL:
            begin
                prod_next = {add_sum[VAL_W:0], prod_reg[VAL_W-1:1]};
                iter_next = iter_reg - ITER_W'(1);
            end
            A_DIV:
            begin
                rem_next  = ge ? add_sum[VAL_W-1:0] : trial[VAL_W-1:0];
                dvd_next  = {dvd_reg[DIV_W-2:0], ge};
                iter_next = iter_reg - ITER_W'(1);
            end
            A_SIGN:
            begin
                if (op_reg == OP_MUL)
                begin
                    res_next = sign_sat(prod_reg >> FRAC_BITS, neg_reg);
                end
                else
                begin
                    res_next = sign_sat(MAG_W'(dvd_reg), neg_reg);
                end
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        neg_reg  <= neg_next;
        iter_reg <= iter_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        dvd_reg  <= dvd_next;
        res_reg  <= res_next;
    end

    assign done   = (state_reg == A_DONE);
    assign result = res_reg;

endmodule

`default_nettype wire

FILE: rtl/core/postfix_expression_evaluator_core.sv
// Postfix expression evaluator over signed Q32.16 values, one element per
// input transaction (tuser gives the kind). An operand is written to the
// stack as it is taken. An operator does up to two stack reads and one
// write around the shared arithmetic unit, whose shift-add multiply runs
// 48 steps and whose restoring divide runs 64 steps, one bit per cycle.
// An end element reads the bottom of the stack and then yields one result
// transaction; the block keeps taking elements while that result waits in
// the output register. The input is not ready while an operator or end
// element is being worked on.
// Depends on pfx_eval_pkg, pfx_eval_stack, pfx_eval_alu and the assert header.
`default_nettype none

`include "postfix_expression_evaluator_core_assert.svh"

module postfix_expression_evaluator_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [55:0] s_tdata,   // operand_value[47:0], op_code[49:48], zero pad
    input  wire logic [1:0]  s_tuser,   // kind[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [47:0] m_tdata,   // result_value[47:0]
    output logic      [1:0]  m_tuser    // status[1:0]
);
    import pfx_eval_pkg::*;

    ctl_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    status_t           err_reg, err_next;
    op_t               op_reg, op_next;
    logic [VAL_W-1:0]  y_reg, y_next;
    logic              binary_reg, binary_next;
    logic              out_valid_reg, out_valid_next;
    logic [VAL_W-1:0]  out_value_reg, out_value_next;
    status_t           out_status_reg, out_status_next;

    logic              accept;
    logic [1:0]        in_kind;
    logic [VAL_W-1:0]  in_value;
    op_t               in_op;
    logic [CNT_W-1:0]  cnt_m1, cnt_m2;
    logic              out_free;

    logic              wr_en, rd_en;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [VAL_W-1:0]  wr_data, rd_data;

    alu_ctrl_t         alu_ctrl;
    logic [VAL_W-1:0]  alu_x, alu_y, alu_result;
    logic              alu_done;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign in_kind  = s_tuser;
    assign in_value = s_tdata[VAL_W-1:0];
    assign in_op    = op_t'(s_tdata[VAL_W+1:VAL_W]);
    assign cnt_m1   = cnt_reg - CNT_W'(1);
    assign cnt_m2   = cnt_reg - CNT_W'(2);
    assign out_free = !out_valid_reg || m_tready;

    // a lone value is negated as 0 - y
    assign alu_x = (state_reg == S_RD_X) ? '0 : rd_data;
    assign alu_y = (state_reg == S_RD_X) ? rd_data : y_reg;

    pfx_eval_stack u_stack (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    pfx_eval_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (alu_ctrl),
        .x      (alu_x),
        .y      (alu_y),
        .done   (alu_done),
        .result (alu_result)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_kind == KIND_OPERATOR && err_reg == ST_OK && cnt_reg != '0)
                    begin
                        state_next = S_RD_Y;
                    end
                    else if (in_kind == KIND_END)
                    begin
                        state_next = S_END_RD;
                    end
                end
            end
            S_RD_Y:
            begin
                state_next = S_RD_X;
            end
            S_RD_X:
            begin
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = (op_reg == OP_SUB) ? S_ALU_WAIT : S_IDLE;
                end
                else
                begin
                    state_next = S_LD_X;
                end
            end
            S_LD_X:
            begin
                state_next = (op_reg == OP_DIV && y_reg == '0) ? S_IDLE : S_ALU_WAIT;
            end
            S_ALU_WAIT:
            begin
                state_next = alu_done ? S_IDLE : S_ALU_WAIT;
            end
            S_END_RD:
            begin
                state_next = S_END_OUT;
            end
            S_END_OUT:
            begin
                state_next = out_free ? S_IDLE : S_END_OUT;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cnt_next        = cnt_reg;
        err_next        = err_reg;
        op_next         = op_reg;
        y_next          = y_reg;
        binary_next     = binary_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        wr_en           = 1'b0;
        wr_addr         = cnt_reg[ADDR_W-1:0];
        wr_data         = in_value;
        rd_en           = 1'b0;
        rd_addr         = '0;
        alu_ctrl.start  = 1'b0;
        alu_ctrl.op     = op_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && err_reg == ST_OK)
                begin
                    priority if (in_kind == KIND_OPERAND)
                    begin
                        if (cnt_reg >= CNT_W'(STACK_DEPTH))
                        begin
                            err_next = ST_OVERFLOW;
                        end
                        else
                        begin
                            wr_en    = 1'b1;
                            cnt_next = cnt_reg + CNT_W'(1);
                        end
                    end
                    else if (in_kind == KIND_OPERATOR)
                    begin
                        if (cnt_reg == '0)
                        begin
                            err_next = ST_ILLEGAL;
                        end
                        else
                        begin
                            op_next = in_op;
                        end
                    end
                    else
                    begin
                        // end element and unused kind leave the stack alone here
                        op_next = op_reg;
                    end
                end
            end
            S_RD_Y:
            begin
                rd_en   = 1'b1;
                rd_addr = cnt_m1[ADDR_W-1:0];
            end
            S_RD_X:
            begin
                y_next = rd_data;
                if (cnt_reg == CNT_W'(1))
                begin
                    binary_next = 1'b0;
                    if (op_reg == OP_SUB)
                    begin
                        alu_ctrl.start = 1'b1;
                    end
                    else if (op_reg != OP_ADD)
                    begin
                        err_next = ST_ILLEGAL;
                    end
                end
                else
                begin
                    binary_next = 1'b1;
                    rd_en       = 1'b1;
                    rd_addr     = cnt_m2[ADDR_W-1:0];
                end
            end
            S_LD_X:
            begin
                if (op_reg == OP_DIV && y_reg == '0)
                begin
                    // both operands are consumed
                    cnt_next = cnt_m2;
                    err_next = ST_DIV_ZERO;
                end
                else
                begin
                    alu_ctrl.start = 1'b1;
                end
            end
            S_ALU_WAIT:
            begin
                if (alu_done)
                begin
                    wr_en   = 1'b1;
                    wr_data = alu_result;
                    if (binary_reg)
                    begin
                        wr_addr  = cnt_m2[ADDR_W-1:0];
                        cnt_next = cnt_m1;
                    end
                    else
                    begin
                        wr_addr = cnt_m1[ADDR_W-1:0];
                    end
                end
            end
            S_END_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = '0;
            end
            S_END_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (err_reg != ST_OK)
                    begin
                        out_status_next = err_reg;
                        out_value_next  = '0;
                    end
                    else if (cnt_reg != CNT_W'(1))
                    begin
                        out_status_next = ST_ILLEGAL;
                        out_value_next  = '0;
                    end
                    else
                    begin
                        out_status_next = ST_OK;
                        out_value_next  = rd_data;
                    end
                    cnt_next = '0;
                    err_next = ST_OK;
                end
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            err_reg       <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        y_reg          <= y_next;
        binary_reg     <= binary_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_status_reg;

    `PFX_ASSERT_HOLDS(a_cnt_bound, 1'b1, cnt_reg <= CNT_W'(STACK_DEPTH))
    `PFX_ASSERT_HOLDS(a_err_zero, m_tvalid && m_tuser != ST_OK, m_tdata == '0)
    `PFX_ASSERT_NEXT(a_end_busy, s_tvalid && s_tready && s_tuser == KIND_END, !s_tready)
    `PFX_ASSERT_HOLDS(a_alu_done_wait, alu_done, state_reg == S_ALU_WAIT)

endmodule

`default_nettype wire

FILE: dv/postfix_expression_evaluator_core_tb.sv
// self-checking testbench for the postfix evaluator core: predicts every
// result from the elements it sends and compares them as they come out
// depends on pfx_eval_pkg and postfix_expression_evaluator_core
`default_nettype none

module postfix_expression_evaluator_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pfx_eval_pkg::*;

    typedef logic signed [VAL_W-1:0] q_t;

    typedef struct {
        q_t      value;
        status_t status;
    } outcome_t;

    localparam q_t Q_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam q_t Q_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam q_t Q_ONE = q_t'(64'sd1 <<< FRAC_BITS);
    localparam logic [MAG_W-1:0] POS_LIMIT = MAG_W'(Q_MAX);
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // directed tests send about 80 elements on top of these
    localparam int RANDOM_ITEMS = 1470;
    localparam int QUIET_ITEMS  = 250;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 150;
    localparam int CYCLE_LIMIT  = 1_000_000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;   // operand_value[47:0], op_code[49:48], zero pad
    logic [1:0]  s_tuser;   // kind[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // result_value[47:0]
    logic [1:0]  m_tuser;   // status[1:0]

    // predictor state
    q_t       eval_stack [STACK_DEPTH];
    int       stack_fill;
    status_t  expr_error;
    outcome_t pending_results [$];

    int sent_items;
    int mismatch_count;
    int hold_off_cycles;
    int cycle_count;
    bit sender_gaps;
    bit receiver_stalls;

    postfix_expression_evaluator_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic q_t saturate(input longint v);
        if (v > longint'(Q_MAX))
            return Q_MAX;
        if (v < longint'(Q_MIN))
            return Q_MIN;
        return q_t'(v);
    endfunction

    function automatic logic [MAG_W-1:0] magnitude_of(input q_t v);
        logic [VAL_W-1:0] m;
        m = v[VAL_W-1] ? -v : v;
        return MAG_W'(m);
    endfunction

    function automatic q_t signed_from_magnitude(input logic [MAG_W-1:0] m, input bit neg);
        if (neg)
            return (m > POS_LIMIT) ? Q_MIN : q_t'(-longint'(m[VAL_W-1:0]));
        return (m > POS_LIMIT) ? Q_MAX : q_t'(m[VAL_W-1:0]);
    endfunction

    function automatic q_t fixed_product(input q_t x, input q_t y);
        logic [MAG_W-1:0] prod;
        prod = magnitude_of(x) * magnitude_of(y);
        return signed_from_magnitude(prod >> FRAC_BITS, x[VAL_W-1] != y[VAL_W-1]);
    endfunction

    function automatic q_t fixed_quotient(input q_t x, input q_t y);
        logic [MAG_W-1:0] num;
        num = magnitude_of(x) << FRAC_BITS;
        return signed_from_magnitude(num / magnitude_of(y), x[VAL_W-1] != y[VAL_W-1]);
    endfunction

    task automatic evaluate_operator(input op_t op);
        q_t x;
        q_t y;
        q_t res;
        if (stack_fill == 0)
        begin
            expr_error = ST_ILLEGAL;
            return;
        end
        y = eval_stack[stack_fill-1];
        // a lone value: minus negates, plus keeps it, the rest are illegal
        if (stack_fill == 1)
        begin
            if (op == OP_SUB)
                eval_stack[0] = saturate(-longint'(y));
            else if (op != OP_ADD)
                expr_error = ST_ILLEGAL;
            return;
        end
        x = eval_stack[stack_fill-2];
        case (op)
            OP_ADD: res = saturate(longint'(x) + longint'(y));
            OP_SUB: res = saturate(longint'(x) - longint'(y));
            OP_MUL: res = fixed_product(x, y);
            default:
            begin
                if (y == 0)
                begin
                    stack_fill -= 2;
                    expr_error = ST_DIV_ZERO;
                    return;
                end
                res = fixed_quotient(x, y);
            end
        endcase
        stack_fill -= 1;
        eval_stack[stack_fill-1] = res;
    endtask

    task automatic predict_element(input logic [1:0] kind, input q_t value, input op_t op);
        outcome_t done;
        case (kind)
            KIND_OPERAND:
            begin
                if (expr_error == ST_OK)
                begin
                    if (stack_fill >= STACK_DEPTH)
                        expr_error = ST_OVERFLOW;
                    else
                    begin
                        eval_stack[stack_fill] = value;
                        stack_fill++;
                    end
                end
            end
            KIND_OPERATOR:
            begin
                if (expr_error == ST_OK)
                begin
                    evaluate_operator(op);
                end
            end
            KIND_END:
            begin
                done.value  = '0;
                done.status = expr_error;
                if (expr_error == ST_OK)
                begin
                    if (stack_fill != 1)
                        done.status = ST_ILLEGAL;
                    else
                        done.value = eval_stack[0];
                end
                pending_results.push_back(done);
                stack_fill = 0;
                expr_error = ST_OK;
            end
            default: ;
        endcase
    endtask

    // ---------------------------------------------------------------- drivers

    task automatic send_element(input logic [1:0] kind, input q_t value, input op_t op);
        if (sender_gaps && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {6'b0, op, value};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent_items++;
        predict_element(kind, value, op);
    endtask

    function automatic q_t any_bits();
        return q_t'({$urandom, $urandom});
    endfunction

    function automatic op_t any_op();
        return op_t'($urandom_range(0, 3));
    endfunction

    // unused value and op fields of each element carry random bits
    task automatic push_operand(input q_t v);
        send_element(KIND_OPERAND, v, any_op());
    endtask

    task automatic apply_operator(input op_t op);
        send_element(KIND_OPERATOR, any_bits(), op);
    endtask

    task automatic end_expression();
        send_element(KIND_END, any_bits(), any_op());
    endtask

    task automatic note_mismatch(input string what);
        if (mismatch_count < 10)
            $display("mismatch at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    task automatic check_result();
        outcome_t want;
        if (pending_results.size() == 0)
        begin
            note_mismatch($sformatf("unexpected result value %h status %0d", m_tdata, m_tuser));
            return;
        end
        want = pending_results.pop_front();
        if (m_tdata !== want.value || m_tuser !== want.status)
            note_mismatch($sformatf("expected value %h status %s, got value %h status %0d",
                                    want.value, want.status.name(), m_tdata, m_tuser));
    endtask

    // result side: checks each transaction, then decides the next ready level
    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                check_result();
            if (hold_off_cycles > 0)
            begin
                m_tready <= 1'b0;
                repeat (hold_off_cycles) @(posedge clk);
                hold_off_cycles = 0;
                m_tready <= 1'b1;
            end
            else if (receiver_stalls && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // ---------------------------------------------------------------- tests

    task automatic test_all_operators();
        push_operand(48'sd229376);      // 3.5
        push_operand(48'sd131072);      // 2.0
        apply_operator(OP_SUB);
        push_operand(-48'sd131072);     // -2.0
        apply_operator(OP_MUL);
        push_operand(48'sd196608);      // 3.0
        apply_operator(OP_DIV);
        push_operand(Q_MAX);
        apply_operator(OP_ADD);
        end_expression();
    endtask

    task automatic test_saturation();
        push_operand(Q_MAX);
        push_operand(Q_MAX);
        apply_operator(OP_ADD);
        push_operand(Q_MIN);
        apply_operator(OP_MUL);
        push_operand(48'sd1);           // smallest step, quotient saturates
        apply_operator(OP_DIV);
        end_expression();
    endtask

    task automatic test_single_value();
        push_operand(Q_MIN);
        apply_operator(OP_SUB);
        apply_operator(OP_ADD);
        send_element(KIND_UNUSED, any_bits(), any_op());
        end_expression();
        push_operand(5 * Q_ONE);
        apply_operator(OP_MUL);
        end_expression();
        push_operand(-Q_ONE);
        apply_operator(OP_DIV);
        end_expression();
    endtask

    task automatic test_stack_faults();
        apply_operator(OP_SUB);
        end_expression();
        // first error sticks, later elements are ignored
        push_operand(7 * Q_ONE);
        push_operand('0);
        apply_operator(OP_DIV);
        push_operand(Q_ONE);
        end_expression();
        push_operand(Q_ONE);
        push_operand(Q_MIN);
        end_expression();
        end_expression();
    endtask

    task automatic test_stack_overflow();
        for (int i = 0; i <= STACK_DEPTH; i++)
            push_operand((i % 2) ? Q_MIN : Q_MAX);
        apply_operator(OP_ADD);
        end_expression();
    endtask

    // result side blocks for a long stretch so the core fills and stalls its input
    task automatic test_output_backpressure();
        hold_off_cycles = HOLD_CYCLES;
        repeat (5)
        begin
            push_operand(any_bits());
            push_operand(any_bits());
            apply_operator(any_op());
            end_expression();
        end
    endtask

    function automatic q_t random_operand();
        case ($urandom_range(0, 9))
            0, 1:
            begin
                case ($urandom_range(0, 5))
                    0: return Q_MAX;
                    1: return Q_MIN;
                    2: return Q_ONE;
                    3: return -Q_ONE;
                    4: return 48'sd1;
                    default: return '0;
                endcase
            end
            2, 3: return any_bits();
            default: return q_t'(int'($urandom_range(0, 1 << 23)) - (1 << 22));
        endcase
    endfunction

    task automatic random_expression();
        int  operands_left;
        int  depth;
        bit  stack_first;
        operands_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 18)
                                                    : $urandom_range(1, 6);
        stack_first = ($urandom_range(0, 3) == 0);
        depth = 0;
        while (operands_left > 0 || depth > 1)
        begin
            if (operands_left > 0 && (depth < 2 || stack_first || $urandom_range(0, 1) == 0))
            begin
                push_operand(random_operand());
                operands_left--;
                depth++;
            end
            else
            begin
                apply_operator(any_op());
                depth--;
            end
        end
        if ($urandom_range(0, 5) == 0)
            apply_operator(any_op());
        end_expression();
    endtask

    task automatic broken_sequence();
        repeat ($urandom_range(1, 12))
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: push_operand(random_operand());
                6, 7:             apply_operator(any_op());
                8:                send_element(KIND_UNUSED, any_bits(), any_op());
                default:          end_expression();
            endcase
        end
    endtask

    task automatic test_random_expressions();
        int start_count;
        start_count = sent_items;
        while (sent_items - start_count < RANDOM_ITEMS)
        begin
            if (sent_items - start_count < RANDOM_ITEMS - QUIET_ITEMS)
            begin
                sender_gaps     = ($urandom_range(0, 3) != 0);
                receiver_stalls = ($urandom_range(0, 3) != 0);
            end
            else
            begin
                sender_gaps     = 1'b0;
                receiver_stalls = 1'b0;
            end
            if ($urandom_range(0, 4) == 0)
                broken_sequence();
            else
                random_expression();
        end
    endtask

    // ---------------------------------------------------------------- sequence

    initial
    begin
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        stack_fill      = 0;
        expr_error      = ST_OK;
        sent_items      = 0;
        mismatch_count  = 0;
        hold_off_cycles = 0;
        sender_gaps     = 1'b1;
        receiver_stalls = 1'b1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_all_operators();
        test_saturation();
        test_single_value();
        test_stack_faults();
        test_stack_overflow();
        test_output_backpressure();
        test_random_expressions();

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
            note_mismatch("expected results never arrived");

        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
+incdir+rtl/core
rtl/core/pfx_eval_pkg.sv
rtl/core/pfx_eval_stack.sv
rtl/core/pfx_eval_alu.sv
rtl/core/postfix_expression_evaluator_core.sv
dv/postfix_expression_evaluator_core_tb.sv
